// ===== sv/floppy_controller_board_glue_unit_defines.svh =====
// assertion macros for the floppy controller board glue unit
// no dependencies; included by the top level
`ifndef FLOPPY_CONTROLLER_BOARD_GLUE_UNIT_DEFINES_SVH
`define FLOPPY_CONTROLLER_BOARD_GLUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FCBG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcbg assertion failed");

// next-cycle implication, disabled in reset
`define FCBG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcbg assertion failed");

`endif

// ===== sv/fcbg_pkg.sv =====
// shared types and constants of the floppy controller board glue unit
// no dependencies
package fcbg_pkg;

    localparam int NUM_DRIVES_DEF = 4;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_STEP  = 2'd3;

    // decode of address bits 5 to 2
    localparam logic [3:0] SEL_FDC  = 4'h4;
    localparam logic [3:0] SEL_CTRL = 4'h5;
    localparam logic [3:0] SEL_TMR  = 4'h6;
    localparam logic [3:0] SEL_ACIA = 4'hC;

    localparam logic [1:0] CFG_DRIVE_ID  = 2'd0;
    localparam logic [1:0] CFG_AVAIL     = 2'd1;
    localparam logic [1:0] CFG_LONG      = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    localparam logic [2:0]  DRIVE_ID_RST = 3'd0;
    localparam logic [3:0]  AVAIL_RST    = 4'd1;
    localparam logic [3:0]  LONG_RST     = 4'd0;
    localparam logic [19:0] TIMEOUT_RST  = 20'd1000000;

    localparam logic [7:0] UNMAPPED    = 8'hFF;
    localparam logic [7:0] TRACK_LONG  = 8'd180;
    localparam logic [7:0] TRACK_SHORT = 8'd90;
    localparam logic [7:0] TRACK_RST   = 8'd20;
    localparam logic [7:0] TRACK_STEP  = 8'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] addr;
        logic [7:0] write_value;
        logic [7:0] fdc_read_value;
        logic [7:0] acia_read_value;
        logic       fdc_irq;
        logic       step_inward;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       fdc_strobe;
        logic       acia_strobe;
        logic [7:0] fdc_write_data;
        logic       motor_on;
        logic       drive_selected;
        logic [1:0] drive_index;
        logic       side_select;
        logic       double_density;
        logic       auto_index;
        logic       nmi_assert;
        logic [7:0] head_track;
    } t_out_item;

    typedef struct packed {
        logic       step;
        logic       inward;
        logic       sel_valid;
        logic [1:0] sel_slot;
    } t_head_ctrl;

endpackage

// ===== sv/fcbg_ctrl.sv =====
// bus decode, control latch, nmi timeout and nmi edge of the glue unit
// depends on fcbg_pkg
module fcbg_ctrl #(
    parameter int NUM_DRIVES = fcbg_pkg::NUM_DRIVES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  fcbg_pkg::t_in_item   i_item,
    input  logic [2:0]           i_drive_id,
    input  logic [3:0]           i_avail_mask,
    input  logic [19:0]          i_timeout_ticks,
    output fcbg_pkg::t_out_item  o_result,
    output fcbg_pkg::t_head_ctrl o_head
);

    logic        r_motor, n_motor;
    logic        r_sel_valid, n_sel_valid;
    logic [1:0]  r_sel_slot, n_sel_slot;
    logic        r_side, n_side;
    logic        r_density, n_density;
    logic        r_auto_index, n_auto_index;
    logic        r_to_enable, n_to_enable;
    logic        r_to_expired, n_to_expired;
    logic [19:0] r_to_count, n_to_count;
    logic        r_running, n_running;
    logic        r_nmi, n_nmi;

    logic [3:0]  sel;
    logic [1:0]  slot;
    logic        slot_ok;
    logic [7:0]  rd;
    logic        fstb;
    logic        astb;
    logic [7:0]  fwd;
    logic        retrig;

    assign sel     = i_item.addr[5:2];
    assign slot    = i_item.write_value[2:1];
    assign slot_ok = (3'(slot) < 3'(NUM_DRIVES)) && i_avail_mask[slot];

    always_comb begin
        n_motor      = r_motor;
        n_sel_valid  = r_sel_valid;
        n_sel_slot   = r_sel_slot;
        n_side       = r_side;
        n_density    = r_density;
        n_auto_index = r_auto_index;
        n_to_enable  = r_to_enable;
        n_to_expired = r_to_expired;
        n_to_count   = r_to_count;
        n_running    = r_running;
        rd           = '0;
        fstb         = 1'b0;
        astb         = 1'b0;
        fwd          = '0;
        retrig       = 1'b0;
        unique case (i_item.op)
            fcbg_pkg::OP_READ: begin
                unique case (sel)
                    fcbg_pkg::SEL_FDC: begin
                        fstb   = 1'b1;
                        retrig = r_to_enable;
                        rd     = ~i_item.fdc_read_value;
                    end
                    fcbg_pkg::SEL_CTRL: begin
                        rd = {3'b111, i_drive_id[2], 2'b00, i_drive_id[1:0]};
                    end
                    fcbg_pkg::SEL_ACIA: begin
                        astb = 1'b1;
                        rd   = i_item.acia_read_value;
                    end
                    default: begin
                        rd = fcbg_pkg::UNMAPPED;
                    end
                endcase
            end
            fcbg_pkg::OP_WRITE: begin
                unique case (sel)
                    fcbg_pkg::SEL_FDC: begin
                        fstb   = 1'b1;
                        fwd    = ~i_item.write_value;
                        retrig = r_to_enable;
                    end
                    fcbg_pkg::SEL_CTRL: begin
                        if (i_item.write_value[3]) begin
                            n_motor     = 1'b1;
                            n_sel_valid = slot_ok;
                            n_sel_slot  = slot_ok ? slot : 2'd0;
                        end else begin
                            n_motor     = 1'b0;
                            n_sel_valid = 1'b0;
                            n_sel_slot  = 2'd0;
                        end
                        n_side = i_item.write_value[0];
                    end
                    fcbg_pkg::SEL_TMR: begin
                        n_to_enable = i_item.write_value[0];
                        if (!i_item.write_value[0]) begin
                            n_running = 1'b0;
                        end
                        n_density    = i_item.write_value[2];
                        n_auto_index = ~i_item.write_value[3];
                    end
                    fcbg_pkg::SEL_ACIA: begin
                        astb = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            fcbg_pkg::OP_TICK: begin
                if (r_running) begin
                    if (r_to_count <= 20'd1) begin
                        n_to_count   = '0;
                        n_running    = 1'b0;
                        n_to_expired = 1'b1;
                    end else begin
                        n_to_count = r_to_count - 20'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (retrig) begin
            n_to_count   = i_timeout_ticks;
            n_running    = 1'b1;
            n_to_expired = 1'b0;
        end
        n_nmi = (!i_item.fdc_irq && n_to_enable) ? n_to_expired : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor      <= 1'b0;
            r_sel_valid  <= 1'b0;
            r_sel_slot   <= 2'd0;
            r_side       <= 1'b0;
            r_density    <= 1'b0;
            r_auto_index <= 1'b1;
            r_to_enable  <= 1'b0;
            r_to_expired <= 1'b0;
            r_to_count   <= '0;
            r_running    <= 1'b0;
            r_nmi        <= 1'b0;
        end else if (i_fire) begin
            r_motor      <= n_motor;
            r_sel_valid  <= n_sel_valid;
            r_sel_slot   <= n_sel_slot;
            r_side       <= n_side;
            r_density    <= n_density;
            r_auto_index <= n_auto_index;
            r_to_enable  <= n_to_enable;
            r_to_expired <= n_to_expired;
            r_to_count   <= n_to_count;
            r_running    <= n_running;
            r_nmi        <= n_nmi;
        end
    end

    always_comb begin
        o_result                = '0;
        o_result.read_data      = rd;
        o_result.fdc_strobe     = fstb;
        o_result.acia_strobe    = astb;
        o_result.fdc_write_data = fwd;
        o_result.motor_on       = n_motor;
        o_result.drive_selected = n_sel_valid;
        o_result.drive_index    = n_sel_valid ? n_sel_slot : 2'd0;
        o_result.side_select    = n_side;
        o_result.double_density = n_density;
        o_result.auto_index     = n_auto_index;
        o_result.nmi_assert     = n_nmi && !r_nmi;
        o_result.head_track     = '0;
    end

    assign o_head.step      = i_fire && (i_item.op == fcbg_pkg::OP_STEP) && r_sel_valid;
    assign o_head.inward    = i_item.step_inward;
    assign o_head.sel_valid = n_sel_valid;
    assign o_head.sel_slot  = n_sel_slot;

endmodule

// ===== sv/fcbg_track.sv =====
// per-drive head position registers with step limits
// depends on fcbg_pkg
module fcbg_track #(
    parameter int NUM_DRIVES = fcbg_pkg::NUM_DRIVES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcbg_pkg::t_head_ctrl i_head,
    input  logic [3:0]           i_long_mask,
    output logic [7:0]           o_track
);

    logic [7:0] r_pos [NUM_DRIVES];
    logic [7:0] n_pos [NUM_DRIVES];

    for (genvar g = 0; g < NUM_DRIVES; g++) begin : g_drive
        logic [7:0] limit;
        logic       hit;

        assign limit = i_long_mask[g] ? fcbg_pkg::TRACK_LONG : fcbg_pkg::TRACK_SHORT;
        assign hit   = i_head.step && (i_head.sel_slot == 2'(g));

        always_comb begin
            n_pos[g] = r_pos[g];
            if (hit) begin
                if (i_head.inward) begin
                    if (r_pos[g] < limit) begin
                        n_pos[g] = r_pos[g] + fcbg_pkg::TRACK_STEP;
                    end
                end else if (r_pos[g] >= fcbg_pkg::TRACK_STEP) begin
                    n_pos[g] = r_pos[g] - fcbg_pkg::TRACK_STEP;
                end else begin
                    n_pos[g] = '0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos[g] <= fcbg_pkg::TRACK_RST;
            end else begin
                r_pos[g] <= n_pos[g];
            end
        end
    end

    always_comb begin
        o_track = fcbg_pkg::TRACK_RST;
        for (int i = 0; i < NUM_DRIVES; i++) begin
            if (i_head.sel_valid && (i_head.sel_slot == 2'(i))) begin
                o_track = n_pos[i];
            end
        end
    end

endmodule

// ===== sv/floppy_controller_board_glue_unit.sv =====
// an accepted item passes the input register and then the result register before its result is valid
// throughput: one item per cycle; a stalled result lets one more item into the input
// register, then input ready drops until the result is taken
// reset: synchronous active low; latch, timer, nmi and head state return to power-on values
// top level of the floppy controller board glue unit
// depends on fcbg_pkg, fcbg_ctrl, fcbg_track and the assertion header
`include "floppy_controller_board_glue_unit_defines.svh"

module floppy_controller_board_glue_unit #(
    parameter int NUM_DRIVES = fcbg_pkg::NUM_DRIVES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fcbg_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fcbg_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_wdata
);

    logic                 r_in_vld;
    fcbg_pkg::t_in_item   r_in;
    logic                 r_out_vld;
    fcbg_pkg::t_out_item  r_out;
    fcbg_pkg::t_out_item  n_out;
    fcbg_pkg::t_out_item  ctrl_res;
    fcbg_pkg::t_head_ctrl head;
    logic                 fire;
    logic [7:0]           track;

    logic [2:0]  r_drive_id;
    logic [3:0]  r_avail;
    logic [3:0]  r_long;
    logic [19:0] r_timeout;

    logic        chk_unsel;
    logic        chk_sel;
    logic        chk_idle_ok;

    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_id <= fcbg_pkg::DRIVE_ID_RST;
            r_avail    <= fcbg_pkg::AVAIL_RST;
            r_long     <= fcbg_pkg::LONG_RST;
            r_timeout  <= fcbg_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcbg_pkg::CFG_DRIVE_ID: r_drive_id <= i_cfg_wdata[2:0];
                fcbg_pkg::CFG_AVAIL:    r_avail    <= i_cfg_wdata[3:0];
                fcbg_pkg::CFG_LONG:     r_long     <= i_cfg_wdata[3:0];
                fcbg_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    fcbg_ctrl #(
        .NUM_DRIVES (NUM_DRIVES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_item          (r_in),
        .i_drive_id      (r_drive_id),
        .i_avail_mask    (r_avail),
        .i_timeout_ticks (r_timeout),
        .o_result        (ctrl_res),
        .o_head          (head)
    );

    fcbg_track #(
        .NUM_DRIVES (NUM_DRIVES)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_long_mask (r_long),
        .o_track     (track)
    );

    always_comb begin
        n_out            = ctrl_res;
        n_out.head_track = track;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    assign chk_unsel   = o_out_valid && !o_out_item.drive_selected;
    assign chk_sel     = o_out_valid && o_out_item.drive_selected;
    assign chk_idle_ok = (o_out_item.head_track == fcbg_pkg::TRACK_RST)
                         && (o_out_item.drive_index == 2'd0);

    `FCBG_ASSERT_NXT(a_fire_gives_result, i_clk, i_rst_n, fire, o_out_valid)
    `FCBG_ASSERT_IMP(a_unselected_track, i_clk, i_rst_n, chk_unsel, chk_idle_ok)
    `FCBG_ASSERT_IMP(a_select_needs_motor, i_clk, i_rst_n, chk_sel, o_out_item.motor_on)
    `FCBG_ASSERT_IMP(a_track_in_range, i_clk, i_rst_n, o_out_valid, o_out_item.head_track <= fcbg_pkg::TRACK_LONG)

endmodule

// ===== bench/floppy_controller_board_glue_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for the floppy controller board glue unit: a queue-fed driver,
// a scoreboarding monitor and a cycle-free predictor of latch, timer, nmi and head state
// depends on fcbg_pkg and floppy_controller_board_glue_unit
module floppy_controller_board_glue_unit_test;

    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} t_action_kind;

    typedef struct {
        t_action_kind       kind;
        fcbg_pkg::t_in_item item;
        logic [1:0]         index;
        logic [19:0]        value;
    } t_bus_action;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    fcbg_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    fcbg_pkg::t_out_item o_out_item;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = '0;
    logic [19:0]         i_cfg_wdata = '0;

    floppy_controller_board_glue_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of configuration and state
    logic [2:0]  cfg_drive_id = fcbg_pkg::DRIVE_ID_RST;
    logic [3:0]  cfg_fitted = fcbg_pkg::AVAIL_RST;
    logic [3:0]  cfg_long = fcbg_pkg::LONG_RST;
    logic [19:0] cfg_ticks = fcbg_pkg::TIMEOUT_RST;

    logic        latch_motor = 1'b0;
    logic        latch_sel_valid = 1'b0;
    logic [1:0]  latch_slot = '0;
    logic        latch_side = 1'b0;
    logic        latch_density = 1'b0;
    logic        latch_auto_index = 1'b1;
    logic        tmo_enable = 1'b0;
    logic        tmo_expired = 1'b0;
    logic [19:0] tmo_count = '0;
    logic        tmo_running = 1'b0;
    logic        nmi_state = 1'b0;
    logic [7:0]  head_pos [4] = '{default: fcbg_pkg::TRACK_RST};

    t_bus_action         bus_actions [$];
    fcbg_pkg::t_out_item glue_results_due [$];

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  settings_used = 0;
    int  nmi_rises = 0;
    int  timeouts_expired = 0;
    int  head_stops = 0;
    logic drv_idle = 1'b0;
    bit  send_free = 1'b0;
    bit  recv_free = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;

    function automatic void restart_timeout();
        tmo_count = cfg_ticks;
        tmo_running = 1'b1;
        tmo_expired = 1'b0;
    endfunction

    function automatic fcbg_pkg::t_out_item predict_glue_result(input fcbg_pkg::t_in_item it);
        fcbg_pkg::t_out_item r;
        logic [3:0]          sel;
        logic [7:0]          limit;
        logic                nmi_now;
        r = '0;
        sel = it.addr[5:2];
        case (it.op)
            fcbg_pkg::OP_READ: begin
                if (sel == fcbg_pkg::SEL_FDC) begin
                    r.fdc_strobe = 1'b1;
                    if (tmo_enable) restart_timeout();
                    r.read_data = ~it.fdc_read_value;
                end else if (sel == fcbg_pkg::SEL_CTRL) begin
                    r.read_data = 8'hE0 + {6'd0, cfg_drive_id[1:0]}
                                  + (cfg_drive_id[2] ? 8'h10 : 8'h00);
                end else if (sel == fcbg_pkg::SEL_ACIA) begin
                    r.acia_strobe = 1'b1;
                    r.read_data = it.acia_read_value;
                end else begin
                    r.read_data = fcbg_pkg::UNMAPPED;
                end
            end
            fcbg_pkg::OP_WRITE: begin
                if (sel == fcbg_pkg::SEL_FDC) begin
                    r.fdc_strobe = 1'b1;
                    r.fdc_write_data = ~it.write_value;
                    if (tmo_enable) restart_timeout();
                end else if (sel == fcbg_pkg::SEL_CTRL) begin
                    if (it.write_value[3]) begin
                        latch_motor = 1'b1;
                        if (cfg_fitted[it.write_value[2:1]]) begin
                            latch_sel_valid = 1'b1;
                            latch_slot = it.write_value[2:1];
                        end else begin
                            latch_sel_valid = 1'b0;
                            latch_slot = '0;
                        end
                    end else begin
                        latch_motor = 1'b0;
                        latch_sel_valid = 1'b0;
                        latch_slot = '0;
                    end
                    latch_side = it.write_value[0];
                end else if (sel == fcbg_pkg::SEL_TMR) begin
                    if (it.write_value[0] != tmo_enable) begin
                        tmo_enable = it.write_value[0];
                        if (!tmo_enable) tmo_running = 1'b0;
                    end
                    latch_density = it.write_value[2];
                    latch_auto_index = ~it.write_value[3];
                end else if (sel == fcbg_pkg::SEL_ACIA) begin
                    r.acia_strobe = 1'b1;
                end
            end
            fcbg_pkg::OP_TICK: begin
                if (tmo_running) begin
                    if (tmo_count <= 20'd1) begin
                        tmo_count = '0;
                        tmo_running = 1'b0;
                        tmo_expired = 1'b1;
                        timeouts_expired++;
                    end else begin
                        tmo_count = tmo_count - 20'd1;
                    end
                end
            end
            default: begin
                if (latch_sel_valid) begin
                    limit = cfg_long[latch_slot] ? fcbg_pkg::TRACK_LONG : fcbg_pkg::TRACK_SHORT;
                    if (it.step_inward) begin
                        if (head_pos[latch_slot] < limit)
                            head_pos[latch_slot] = head_pos[latch_slot] + fcbg_pkg::TRACK_STEP;
                        else
                            head_stops++;
                    end else begin
                        if (head_pos[latch_slot] >= fcbg_pkg::TRACK_STEP)
                            head_pos[latch_slot] = head_pos[latch_slot] - fcbg_pkg::TRACK_STEP;
                        else if (head_pos[latch_slot] != 8'd0)
                            head_pos[latch_slot] = 8'd0;
                        else
                            head_stops++;
                    end
                end
            end
        endcase
        nmi_now = (!it.fdc_irq && tmo_enable) ? tmo_expired : 1'b1;
        r.nmi_assert = nmi_now && !nmi_state;
        if (r.nmi_assert) nmi_rises++;
        nmi_state = nmi_now;
        r.motor_on = latch_motor;
        r.drive_selected = latch_sel_valid;
        r.drive_index = latch_sel_valid ? latch_slot : 2'd0;
        r.side_select = latch_side;
        r.double_density = latch_density;
        r.auto_index = latch_auto_index;
        r.head_track = latch_sel_valid ? head_pos[latch_slot] : fcbg_pkg::TRACK_RST;
        return r;
    endfunction

    function automatic fcbg_pkg::t_in_item make_item(input logic [1:0] op,
                                                     input logic [9:0] addr,
                                                     input logic [7:0] wv,
                                                     input logic [7:0] frd,
                                                     input logic [7:0] ard,
                                                     input logic irq,
                                                     input logic inward);
        fcbg_pkg::t_in_item it;
        it.op = op;
        it.addr = addr;
        it.write_value = wv;
        it.fdc_read_value = frd;
        it.acia_read_value = ard;
        it.fdc_irq = irq;
        it.step_inward = inward;
        return it;
    endfunction

    function automatic fcbg_pkg::t_in_item random_bus_item();
        fcbg_pkg::t_in_item it;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) it.op = fcbg_pkg::OP_READ;
        else if (pick < 55) it.op = fcbg_pkg::OP_WRITE;
        else if (pick < 80) it.op = fcbg_pkg::OP_TICK;
        else it.op = fcbg_pkg::OP_STEP;
        it.addr = 10'($urandom);
        if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 3))
                0: it.addr[5:2] = fcbg_pkg::SEL_FDC;
                1: it.addr[5:2] = fcbg_pkg::SEL_CTRL;
                2: it.addr[5:2] = fcbg_pkg::SEL_TMR;
                default: it.addr[5:2] = fcbg_pkg::SEL_ACIA;
            endcase
        end
        it.write_value = 8'($urandom);
        if (it.op == fcbg_pkg::OP_WRITE && it.addr[5:2] == fcbg_pkg::SEL_CTRL
            && $urandom_range(0, 3) != 0)
            it.write_value[3] = 1'b1;
        it.fdc_read_value = 8'($urandom);
        it.acia_read_value = 8'($urandom);
        it.fdc_irq = ($urandom_range(0, 4) == 0);
        it.step_inward = 1'($urandom);
        return it;
    endfunction

    task automatic queue_item(input fcbg_pkg::t_in_item it);
        t_bus_action a;
        a.kind = ACT_ITEM;
        a.item = it;
        a.index = '0;
        a.value = '0;
        bus_actions = {bus_actions, a};
    endtask

    task automatic queue_drain();
        t_bus_action a;
        a.kind = ACT_DRAIN;
        a.item = '0;
        a.index = '0;
        a.value = '0;
        bus_actions = {bus_actions, a};
    endtask

    task automatic queue_setting(input logic [2:0] id, input logic [3:0] fitted,
                                 input logic [3:0] long_tracks, input logic [19:0] ticks);
        t_bus_action a;
        queue_drain();
        a.kind = ACT_CFG;
        a.item = '0;
        a.index = fcbg_pkg::CFG_DRIVE_ID;
        a.value = {17'd0, id};
        bus_actions = {bus_actions, a};
        a.index = fcbg_pkg::CFG_AVAIL;
        a.value = {16'd0, fitted};
        bus_actions = {bus_actions, a};
        a.index = fcbg_pkg::CFG_LONG;
        a.value = {16'd0, long_tracks};
        bus_actions = {bus_actions, a};
        a.index = fcbg_pkg::CFG_TIMEOUT;
        a.value = ticks;
        bus_actions = {bus_actions, a};
        settings_used++;
    endtask

    task automatic queue_random_phase(input int n_items, input bit mid_drain);
        int                 count;
        int                 len;
        bit                 inward;
        bit                 ticks_only;
        fcbg_pkg::t_in_item it;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(0, 99) < 6) begin
                // burst of steps in one direction or of ticks, to reach limits and expiry
                len = $urandom_range(10, 50);
                inward = 1'($urandom);
                ticks_only = ($urandom_range(0, 2) == 0);
                repeat (len) begin
                    it = random_bus_item();
                    it.op = ticks_only ? fcbg_pkg::OP_TICK : fcbg_pkg::OP_STEP;
                    it.step_inward = inward;
                    queue_item(it);
                end
                count += len;
            end else begin
                queue_item(random_bus_item());
                count++;
            end
            if (mid_drain && count >= n_items / 2 && count < n_items / 2 + 1)
                queue_drain();
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        logic               nxt_valid;
        fcbg_pkg::t_in_item nxt_item;
        logic               nxt_we;
        logic [1:0]         nxt_index;
        logic [19:0]        nxt_data;
        t_bus_action        act;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_we <= 1'b0;
            drv_idle <= 1'b0;
            gap_left = 0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_item = i_in_item;
            nxt_we = 1'b0;
            nxt_index = i_cfg_index;
            nxt_data = i_cfg_wdata;
            if (i_in_valid && o_in_ready) begin
                glue_results_due = {glue_results_due, predict_glue_result(i_in_item)};
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0) send_free = !send_free;
                gap_left = send_free ? 0 : $urandom_range(0, 8);
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (bus_actions.size() > 0) begin
                    act = bus_actions[0];
                    case (act.kind)
                        ACT_ITEM: begin
                            nxt_item = act.item;
                            nxt_valid = 1'b1;
                            bus_actions.delete(0);
                        end
                        ACT_CFG: begin
                            nxt_we = 1'b1;
                            nxt_index = act.index;
                            nxt_data = act.value;
                            case (act.index)
                                fcbg_pkg::CFG_DRIVE_ID: cfg_drive_id = act.value[2:0];
                                fcbg_pkg::CFG_AVAIL:    cfg_fitted = act.value[3:0];
                                fcbg_pkg::CFG_LONG:     cfg_long = act.value[3:0];
                                default:                cfg_ticks = act.value;
                            endcase
                            bus_actions.delete(0);
                        end
                        default: begin
                            if (glue_results_due.size() == 0) bus_actions.delete(0);
                        end
                    endcase
                end
            end
            i_in_valid <= nxt_valid;
            i_in_item <= nxt_item;
            i_cfg_we <= nxt_we;
            i_cfg_index <= nxt_index;
            i_cfg_wdata <= nxt_data;
            drv_idle <= (bus_actions.size() == 0) && !nxt_valid;
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        fcbg_pkg::t_out_item want;
        string               bad;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (glue_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item %h", o_out_item);
                end else begin
                    want = glue_results_due[0];
                    glue_results_due.delete(0);
                    bad = "";
                    if (o_out_item.read_data !== want.read_data) bad = {bad, " read_data"};
                    if (o_out_item.fdc_strobe !== want.fdc_strobe) bad = {bad, " fdc_strobe"};
                    if (o_out_item.acia_strobe !== want.acia_strobe) bad = {bad, " acia_strobe"};
                    if (o_out_item.fdc_write_data !== want.fdc_write_data)
                        bad = {bad, " fdc_write_data"};
                    if (o_out_item.motor_on !== want.motor_on) bad = {bad, " motor_on"};
                    if (o_out_item.drive_selected !== want.drive_selected)
                        bad = {bad, " drive_selected"};
                    if (o_out_item.drive_index !== want.drive_index) bad = {bad, " drive_index"};
                    if (o_out_item.side_select !== want.side_select) bad = {bad, " side_select"};
                    if (o_out_item.double_density !== want.double_density)
                        bad = {bad, " double_density"};
                    if (o_out_item.auto_index !== want.auto_index) bad = {bad, " auto_index"};
                    if (o_out_item.nmi_assert !== want.nmi_assert) bad = {bad, " nmi_assert"};
                    if (o_out_item.head_track !== want.head_track) bad = {bad, " head_track"};
                    if (bad != "") begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d differs in%s: expected %h, got %h",
                                     results_checked, bad, want, o_out_item);
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_free = !recv_free;
                stall_left = recv_free ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        // directed items under reset configuration
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h014, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h3D3, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1));
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h010, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h010, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h3D3, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h030, 8'h00, 8'h00, 8'hA5, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h3F3, 8'h00, 8'h00, 8'h5A, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h030, 8'h3C, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h3FF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h01C, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
        // step with nothing selected
        queue_item(make_item(fcbg_pkg::OP_STEP, 10'h000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h014, 8'h09, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_STEP, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        queue_item(make_item(fcbg_pkg::OP_STEP, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        // slot not fitted
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h014, 8'h0B, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h018, 8'h0D, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h010, 8'h55, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h018, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_TICK, 10'h000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        // zero timeout behaves as a single tick
        queue_setting(3'd7, 4'hF, 4'h5, 20'd0);
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h014, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h018, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_READ, 10'h010, 8'h00, 8'h12, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_TICK, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(fcbg_pkg::OP_WRITE, 10'h014, 8'h0F, 8'h00, 8'h00, 1'b0, 1'b0));

        queue_setting(3'd0, 4'h0, 4'h0, 20'd1);
        queue_random_phase(216, 1'b0);
        queue_setting(3'd7, 4'hF, 4'hF, 20'hFFFFF);
        queue_random_phase(216, 1'b0);
        for (int p = 0; p < 4; p++) begin
            queue_setting(3'($urandom), 4'($urandom), 4'($urandom),
                          20'($urandom_range(1, 60)));
            queue_random_phase(216, p == 0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!(drv_idle && glue_results_due.size() == 0));
        repeat (4) @(posedge i_clk);
        mismatch_count += glue_results_due.size();
        $display("checked %0d results across %0d register settings", results_checked,
                 settings_used);
        $display("saw %0d nmi rises, %0d timeout expiries, %0d steps held at a track end",
                 nmi_rises, timeouts_expired, head_stops);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results still due", glue_results_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/fcbg_pkg.sv
sv/fcbg_ctrl.sv
sv/fcbg_track.sv
sv/floppy_controller_board_glue_unit.sv
bench/floppy_controller_board_glue_unit_test.sv
